>>> rtl/jwrs_pkg.sv
// ----------------------------------------------------------------------------
// jwrs_pkg: shared definitions for the rotation scheduler
// constants, codes, fsm states and divider request/response types
// ----------------------------------------------------------------------------
package jwrs_pkg;

	// device count saturation and type table
	localparam int COUNT_MAX  = 63;
	localparam int NUM_TYPES  = 5;
	localparam int CNT_W      = 6;
	localparam int TYPE_W     = 3;
	localparam int WEIGHT_MAX = 1 + 3 * COUNT_MAX;
	localparam int TOTAL_W    = $clog2(NUM_TYPES * WEIGHT_MAX + 1);

	// interval arithmetic
	localparam int BASE_W       = 17;
	localparam int JIT_W        = 7;
	localparam int PROD_W       = BASE_W + JIT_W;
	localparam int INTV_W       = 18;
	localparam int TIME_W       = 32;
	localparam int RAND_W       = 32;
	localparam int SPAN_DIVISOR = 100;
	localparam int INTERVAL_MAX = 262143;

	// shared serial divider
	localparam int DIV_W  = 32;
	localparam int DVS_W  = INTV_W;
	localparam int ITER_W = $clog2(DIV_W + 1);

	// configuration port
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [BASE_W-1:0] PERIOD_NORMAL_RST   = BASE_W'(2500);
	localparam logic [BASE_W-1:0] PERIOD_DESERTED_RST = BASE_W'(5000);
	localparam logic [BASE_W-1:0] PERIOD_CROWDED_RST  = BASE_W'(1500);
	localparam logic [JIT_W-1:0]  JITTER_RST          = JIT_W'(40);

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_START = 2'd1,
		ACT_STOP  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		TIER_DESERTED = 2'd0,
		TIER_NORMAL   = 2'd1,
		TIER_CROWDED  = 2'd2,
		TIER_DENSE    = 2'd3
	} tier_t;

	typedef enum logic [1:0] {
		REG_PERIOD_NORMAL   = 2'd0,
		REG_PERIOD_DESERTED = 2'd1,
		REG_PERIOD_CROWDED  = 2'd2,
		REG_JITTER          = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_PICK,
		ST_SPAN,
		ST_BOUND,
		ST_DRAW,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DVS_W-1:0]  divisor;
		logic [ITER_W-1:0] iters;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
		logic [DVS_W-1:0] remainder;
	} div_rsp_t;

endpackage

>>> rtl/jittered_weighted_rotation_scheduler_unit.sv
// ----------------------------------------------------------------------------
// jittered_weighted_rotation_scheduler_unit: beacon rotation scheduler
// weighted type choice and jittered interval draw on a shared serial divider
// ----------------------------------------------------------------------------
// flow: start, stop, idle and non-due ticks go from evaluation straight to the
//   result register; a rotating tick first runs the pick, span, bound and draw states
// handshake: no new request is taken until the last result is committed; a
//   rotation is set by three passes of the one-bit-per-cycle divider (32, 24
//   and 32 steps); a result held by the sink stalls the input
// reset: config registers load their defaults, scheduler state clears, no
//   clearing pass; the next request can be taken right after reset
// ----------------------------------------------------------------------------
module jittered_weighted_rotation_scheduler_unit import jwrs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,

	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,

	// event request
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  logic [TIME_W-1:0]   now_ms,
	input  logic                radio_ready,
	input  logic [CNT_W-1:0]    count_type0,
	input  logic [CNT_W-1:0]    count_type1,
	input  logic [CNT_W-1:0]    count_type2,
	input  logic [CNT_W-1:0]    count_type3,
	input  logic [CNT_W-1:0]    count_type4,
	input  logic [1:0]          crowd_tier,
	input  logic [RAND_W-1:0]   random_pick,
	input  logic [RAND_W-1:0]   random_jitter,

	// result request
	output logic                out_valid,
	input  logic                out_ready,
	output logic                rotate,
	output logic                halt_beacon,
	output logic [TYPE_W-1:0]   beacon_type,
	output logic [INTV_W-1:0]   next_interval_ms,
	output logic                is_active
);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [BASE_W-1:0] period_normal_q;
	logic [BASE_W-1:0] period_deserted_q;
	logic [BASE_W-1:0] period_crowded_q;
	logic [JIT_W-1:0]  jitter_q;
	logic              cfg_wr;
	reg_idx_t          cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_normal_q   <= PERIOD_NORMAL_RST;
			period_deserted_q <= PERIOD_DESERTED_RST;
			period_crowded_q  <= PERIOD_CROWDED_RST;
			jitter_q          <= JITTER_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_PERIOD_NORMAL:   period_normal_q   <= pwdata[BASE_W-1:0];
				REG_PERIOD_DESERTED: period_deserted_q <= pwdata[BASE_W-1:0];
				REG_PERIOD_CROWDED:  period_crowded_q  <= pwdata[BASE_W-1:0];
				REG_JITTER:          jitter_q          <= pwdata[JIT_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback, zero extended
	always_comb begin
		unique case (cfg_idx)
			REG_PERIOD_NORMAL:   prdata = DATA_W'(period_normal_q);
			REG_PERIOD_DESERTED: prdata = DATA_W'(period_deserted_q);
			REG_PERIOD_CROWDED:  prdata = DATA_W'(period_crowded_q);
			REG_JITTER:          prdata = DATA_W'(jitter_q);
			default:             prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// fsm and handshake control
	// ------------------------------------------------------------------
	state_t   state_q;
	state_t   state_nxt;
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic     accept;
	logic     commit;
	logic     out_valid_q;

	// ------------------------------------------------------------------
	// captured request fields (payload, no reset)
	// ------------------------------------------------------------------
	action_t           action_q;
	logic [TIME_W-1:0] now_q;
	logic              ready_q;
	logic [CNT_W-1:0]  cnt_q [NUM_TYPES];
	tier_t             tier_q;
	logic [RAND_W-1:0] rpick_q;
	logic [RAND_W-1:0] rjit_q;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action_t'(action);
			now_q    <= now_ms;
			ready_q  <= radio_ready;
			cnt_q[0] <= count_type0;
			cnt_q[1] <= count_type1;
			cnt_q[2] <= count_type2;
			cnt_q[3] <= count_type3;
			cnt_q[4] <= count_type4;
			tier_q   <= tier_t'(crowd_tier);
			rpick_q  <= random_pick;
			rjit_q   <= random_jitter;
		end
	end

	// ------------------------------------------------------------------
	// scheduler state
	// ------------------------------------------------------------------
	logic              running_q;
	logic              first_q;
	logic [TIME_W-1:0] last_q;
	logic [INTV_W-1:0] interval_q;
	logic [TYPE_W-1:0] type_q;

	// ------------------------------------------------------------------
	// roulette wheel: saturated counts, weights 1 + 3c, running sums
	// ------------------------------------------------------------------
	logic [TOTAL_W-1:0] cum [NUM_TYPES];
	logic [TOTAL_W-1:0] total;
	logic [TOTAL_W-1:0] pick_pt;
	logic [TYPE_W-1:0]  pick_type;

	always_comb begin
		logic [CNT_W-1:0]   sat;
		logic [TOTAL_W-1:0] run;
		run = '0;
		for (int i = 0; i < NUM_TYPES; i++) begin
			sat = cnt_q[i];
			if (int'(cnt_q[i]) > COUNT_MAX) begin
				sat = CNT_W'(COUNT_MAX);
			end
			run    = run + TOTAL_W'(1 + 3 * int'(sat));
			cum[i] = run;
		end
	end

	assign total   = cum[NUM_TYPES-1];
	assign pick_pt = div_rsp.remainder[TOTAL_W-1:0];

	// first type whose running sum exceeds the pick point
	always_comb begin
		pick_type = '0;
		for (int i = NUM_TYPES - 1; i >= 0; i--) begin
			if (pick_pt < cum[i]) begin
				pick_type = TYPE_W'(i);
			end
		end
	end

	// ------------------------------------------------------------------
	// event decode
	// ------------------------------------------------------------------
	logic [TIME_W-1:0] elapsed;
	logic              due;
	logic              rot_ev;
	logic              start_ev;
	logic              stop_ev;
	logic              halt_ev;

	// wrapping elapsed time since the last rotation
	assign elapsed  = now_q - last_q;
	assign due      = first_q || (elapsed >= TIME_W'(interval_q));
	assign rot_ev   = (action_q == ACT_TICK) && running_q && ready_q && due;
	assign start_ev = (action_q == ACT_START) && !running_q && ready_q;
	assign stop_ev  = (action_q == ACT_STOP) && running_q;
	// the first rotation after a start has nothing on air to stop
	assign halt_ev  = stop_ev || (rot_ev && !first_q);

	// ------------------------------------------------------------------
	// interval draw: base by tier, span = base * pct / 100, bounds
	// ------------------------------------------------------------------
	logic [BASE_W-1:0] base;
	logic [PROD_W-1:0] prod_q;
	logic [INTV_W-1:0] span;
	logic [INTV_W-1:0] lo;
	logic [INTV_W:0]   hi_full;
	logic [INTV_W-1:0] hi_sat;
	logic [INTV_W-1:0] hi;
	logic [INTV_W-1:0] rng;
	logic [INTV_W-1:0] lo_q;
	logic [TYPE_W-1:0] new_type_q;
	logic [INTV_W-1:0] new_intv_q;

	always_comb begin
		case (tier_q)
			TIER_DESERTED: base = period_deserted_q;
			TIER_NORMAL:   base = period_normal_q;
			default:       base = period_crowded_q;
		endcase
	end

	// span never exceeds 18 bits even for the largest register contents
	assign span    = div_rsp.quotient[INTV_W-1:0];
	// lo exceeds the base only for a zero base (lo is then 1), so only hi can need saturation
	assign lo      = ({1'b0, base} > span) ? (INTV_W'(base) - span) : INTV_W'(1);
	assign hi_full = (INTV_W + 1)'(base) + (INTV_W + 1)'(span);
	assign hi_sat  = (hi_full > (INTV_W + 1)'(INTERVAL_MAX)) ? INTV_W'(INTERVAL_MAX)
	                                                        : hi_full[INTV_W-1:0];
	// zero base gives hi below lo: collapse to a single value
	assign hi      = (hi_sat < lo) ? lo : hi_sat;
	assign rng     = hi - lo + INTV_W'(1);

	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL) begin
			prod_q <= PROD_W'(base) * PROD_W'(jitter_q);
		end
		if (state_q == ST_PICK && div_rsp.done) begin
			new_type_q <= pick_type;
		end
		if (state_q == ST_BOUND) begin
			lo_q <= lo;
		end
		if (state_q == ST_DRAW && div_rsp.done) begin
			new_intv_q <= lo_q + div_rsp.remainder;
		end
	end

	// shared divider: pick modulo, span by 100, jitter modulo
	jwrs_serdiv u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ------------------------------------------------------------------
	// fsm: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_nxt = ST_EVAL;
			ST_EVAL:  state_nxt = rot_ev ? ST_PICK : ST_DONE;
			ST_PICK:  if (div_rsp.done) state_nxt = ST_SPAN;
			ST_SPAN:  if (div_rsp.done) state_nxt = ST_BOUND;
			ST_BOUND: state_nxt = ST_DRAW;
			ST_DRAW:  if (div_rsp.done) state_nxt = ST_DONE;
			ST_DONE:  if (!out_valid_q || out_ready) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// fsm: outputs
	// ------------------------------------------------------------------
	always_comb begin
		in_ready = 1'b0;
		commit   = 1'b0;
		div_req  = '0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_EVAL: begin
				if (rot_ev) begin
					div_req.start    = 1'b1;
					div_req.dividend = DIV_W'(rpick_q);
					div_req.divisor  = DVS_W'(total);
					div_req.iters    = ITER_W'(DIV_W);
				end
			end
			ST_PICK: begin
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = {prod_q, {(DIV_W - PROD_W){1'b0}}};
					div_req.divisor  = DVS_W'(SPAN_DIVISOR);
					div_req.iters    = ITER_W'(PROD_W);
				end
			end
			ST_BOUND: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'(rjit_q);
				div_req.divisor  = rng;
				div_req.iters    = ITER_W'(DIV_W);
			end
			ST_DONE: commit = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// ------------------------------------------------------------------
	// commit: update scheduler state and load the result register
	// ------------------------------------------------------------------
	logic              nxt_running;
	logic              nxt_first;
	logic [INTV_W-1:0] nxt_interval;
	logic [TYPE_W-1:0] nxt_type;

	always_comb begin
		nxt_running  = running_q;
		nxt_first    = first_q;
		nxt_interval = interval_q;
		nxt_type     = type_q;
		if (start_ev) begin
			nxt_running  = 1'b1;
			nxt_first    = 1'b1;
			nxt_interval = '0;
			nxt_type     = '0;
		end else if (stop_ev) begin
			nxt_running = 1'b0;
		end else if (rot_ev) begin
			nxt_first    = 1'b0;
			nxt_interval = new_intv_q;
			nxt_type     = new_type_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= 1'b0;
			first_q    <= 1'b0;
			last_q     <= '0;
			interval_q <= '0;
			type_q     <= '0;
		end else if (commit) begin
			running_q  <= nxt_running;
			first_q    <= nxt_first;
			interval_q <= nxt_interval;
			type_q     <= nxt_type;
			if (rot_ev) begin
				last_q <= now_q;
			end
		end
	end

	// result register parts the two sides
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rotate           <= rot_ev;
			halt_beacon      <= halt_ev;
			beacon_type      <= nxt_type;
			next_interval_ms <= nxt_interval;
			is_active        <= nxt_running;
		end
	end

	assign out_valid = out_valid_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EVAL))
		else $error("accepted request did not enter evaluation");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_PICK || state_q == ST_SPAN || state_q == ST_DRAW))
		else $error("divider finished outside a divide state");

	a_rotate_active: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rotate) |-> (is_active && next_interval_ms != '0))
		else $error("rotation reported without activity or interval");

	a_halt_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && halt_beacon && !rotate) |-> !is_active)
		else $error("halt without rotation left the scheduler active");

endmodule

>>> rtl/jwrs_serdiv.sv
// ----------------------------------------------------------------------------
// jwrs_serdiv: bit-serial restoring divider
// one quotient bit per cycle, dividend left aligned, iteration count per request
// ----------------------------------------------------------------------------
module jwrs_serdiv import jwrs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] cnt_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dvd_q;
	logic [DVS_W-1:0]  dvs_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;
	logic [DVS_W-1:0] rem_nxt;

	// shift next dividend bit into the partial remainder
	assign trial   = {rem_q, dvd_q[DIV_W-1]};
	assign ge      = trial >= {1'b0, dvs_q};
	assign diff    = trial - {1'b0, dvs_q};
	assign rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - ITER_W'(1);
				if (cnt_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = dvd_q;
	assign rsp.remainder = rem_q;

endmodule
